>>> sv/arm_pkg.sv
package arm_pkg;

    localparam int LEN_W = 7;
    localparam int CD_W = 20;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_ACK = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_TX = 2'd0;
    localparam logic [1:0] KIND_ACK = 2'd1;
    localparam logic [1:0] KIND_GIVEUP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_STEP = 2'd2;

    localparam logic [3:0] RESET_RETRY_LIMIT = 4'd3;
    localparam logic [15:0] RESET_TIMEOUT = 16'd2000;
    localparam logic [15:0] RESET_BACKOFF_STEP = 16'd500;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] node_addr;
        logic [7:0] seq_num;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [7:0] peer_addr;
        logic [7:0] seq_out;
        logic [3:0] attempt;
    } result_t;

    typedef enum logic [1:0] {
        CMD_TX,
        CMD_REPORT,
        CMD_REPLAY
    } cmd_op_t;

    // count is the store write address for CMD_TX and the length for CMD_REPLAY
    typedef struct packed {
        cmd_op_t          op;
        logic [1:0]       kind;
        logic [7:0]       data;
        logic             last;
        logic [7:0]       peer;
        logic [7:0]       seq;
        logic [3:0]       attempt;
        logic             wr_en;
        logic [LEN_W-1:0] count;
    } cmd_t;

endpackage

>>> sv/arm_front.sv
module arm_front #(
    parameter int PKT_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  arm_pkg::item_t                 item,
    input  logic                           cfg_we,
    input  logic [arm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           push,
    output arm_pkg::cmd_t                  cmd
);

    logic [3:0]  retry_limit_reg;
    logic [15:0] timeout_reg;
    logic [15:0] backoff_step_reg;

    logic                      pending_reg, pending_next;
    logic                      loading_reg, loading_next;
    logic                      backoff_reg, backoff_next;
    logic [7:0]                peer_reg, peer_next;
    logic [7:0]                seq_reg, seq_next;
    logic [3:0]                retries_reg, retries_next;
    logic [arm_pkg::CD_W-1:0]  cd_reg, cd_next;
    logic [arm_pkg::LEN_W-1:0] len_reg, len_next;

    logic [arm_pkg::LEN_W-1:0] len_cur;
    logic [7:0]                peer_cur;
    logic [7:0]                seq_cur;
    logic                      store_wr;
    logic [arm_pkg::CD_W-1:0]  cd_dec;
    logic [3:0]                used;
    logic [3:0]                retries_dec;
    logic [3:0]                used_dec;
    logic [arm_pkg::CD_W-1:0]  backoff_cd;

    assign used = retry_limit_reg - retries_reg;
    assign retries_dec = retries_reg - 4'd1;
    assign used_dec = retry_limit_reg - retries_dec;
    assign backoff_cd = arm_pkg::CD_W'(backoff_step_reg) * arm_pkg::CD_W'(used_dec);
    assign cd_dec = (cd_reg != '0) ? cd_reg - 1'b1 : cd_reg;

    assign len_cur = loading_reg ? len_reg : '0;
    assign peer_cur = loading_reg ? peer_reg : item.node_addr;
    assign seq_cur = loading_reg ? seq_reg : item.seq_num;
    assign store_wr = len_cur < arm_pkg::LEN_W'(PKT_DEPTH);

    always_comb
    begin
        pending_next = pending_reg;
        loading_next = loading_reg;
        backoff_next = backoff_reg;
        peer_next = peer_reg;
        seq_next = seq_reg;
        retries_next = retries_reg;
        cd_next = cd_reg;
        len_next = len_reg;
        push = 1'b0;
        cmd = '0;
        cmd.op = arm_pkg::CMD_REPORT;
        cmd.peer = peer_reg;
        cmd.seq = seq_reg;
        if (accept)
        begin
            unique case (item.operation)
                arm_pkg::OP_SEND:
                begin
                    pending_next = 1'b0;
                    backoff_next = 1'b0;
                    loading_next = 1'b1;
                    peer_next = peer_cur;
                    seq_next = seq_cur;
                    len_next = len_cur + arm_pkg::LEN_W'(store_wr);
                    push = 1'b1;
                    cmd.op = arm_pkg::CMD_TX;
                    cmd.kind = arm_pkg::KIND_TX;
                    cmd.data = item.data_byte;
                    cmd.last = item.last_byte;
                    cmd.peer = peer_cur;
                    cmd.seq = seq_cur;
                    cmd.wr_en = store_wr;
                    cmd.count = len_cur;
                    if (item.last_byte)
                    begin
                        loading_next = 1'b0;
                        pending_next = 1'b1;
                        retries_next = retry_limit_reg;
                        cd_next = arm_pkg::CD_W'(timeout_reg);
                    end
                end
                arm_pkg::OP_ACK:
                begin
                    if (pending_reg && peer_reg == item.node_addr && seq_reg == item.seq_num)
                    begin
                        pending_next = 1'b0;
                        backoff_next = 1'b0;
                        push = 1'b1;
                        cmd.kind = arm_pkg::KIND_ACK;
                        cmd.attempt = used;
                    end
                end
                arm_pkg::OP_TICK:
                begin
                    if (pending_reg)
                    begin
                        cd_next = cd_dec;
                        if (cd_dec == '0)
                        begin
                            if (backoff_reg)
                            begin
                                push = 1'b1;
                                cmd.op = arm_pkg::CMD_REPLAY;
                                cmd.attempt = used;
                                cmd.count = len_reg;
                                backoff_next = 1'b0;
                                cd_next = arm_pkg::CD_W'(timeout_reg);
                            end
                            else if (retries_reg == '0)
                            begin
                                pending_next = 1'b0;
                                push = 1'b1;
                                cmd.kind = arm_pkg::KIND_GIVEUP;
                                cmd.attempt = used;
                            end
                            else
                            begin
                                retries_next = retries_dec;
                                // zero backoff replays within the same tick
                                if (backoff_cd == '0)
                                begin
                                    push = 1'b1;
                                    cmd.op = arm_pkg::CMD_REPLAY;
                                    cmd.attempt = used_dec;
                                    cmd.count = len_reg;
                                    cd_next = arm_pkg::CD_W'(timeout_reg);
                                end
                                else
                                begin
                                    backoff_next = 1'b1;
                                    cd_next = backoff_cd;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= arm_pkg::RESET_RETRY_LIMIT;
            timeout_reg <= arm_pkg::RESET_TIMEOUT;
            backoff_step_reg <= arm_pkg::RESET_BACKOFF_STEP;
            pending_reg <= 1'b0;
            loading_reg <= 1'b0;
            backoff_reg <= 1'b0;
            peer_reg <= '0;
            seq_reg <= '0;
            retries_reg <= '0;
            cd_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            loading_reg <= loading_next;
            backoff_reg <= backoff_next;
            peer_reg <= peer_next;
            seq_reg <= seq_next;
            retries_reg <= retries_next;
            cd_reg <= cd_next;
            len_reg <= len_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    arm_pkg::CFG_RETRY_LIMIT:  retry_limit_reg <= cfg_data[3:0];
                    arm_pkg::CFG_TIMEOUT:      timeout_reg <= cfg_data;
                    arm_pkg::CFG_BACKOFF_STEP: backoff_step_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

>>> sv/arm_cmd_fifo.sv
module arm_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  arm_pkg::cmd_t push_cmd,
    input  logic          pop,
    output arm_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    arm_pkg::cmd_t entries_reg [arm_pkg::FIFO_DEPTH];

    logic [arm_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [arm_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [arm_pkg::FIFO_CNT_W-1:0] count_reg;

    assign empty = count_reg == '0;
    assign full = count_reg == arm_pkg::FIFO_CNT_W'(arm_pkg::FIFO_DEPTH);
    assign head = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/arm_back.sv
module arm_back #(
    parameter int PKT_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  arm_pkg::cmd_t    head,
    input  logic             empty,
    output logic             pop,
    output logic             result_valid,
    output arm_pkg::result_t result
);

    localparam int AW = (PKT_DEPTH > 1) ? $clog2(PKT_DEPTH) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_REPLAY
    } state_t;

    state_t state_reg;

    logic [7:0] store_mem [PKT_DEPTH];

    logic                      out_valid_reg;
    arm_pkg::result_t          out_reg;
    logic                      rd_valid_reg;
    logic                      rd_last_reg;
    logic [7:0]                rd_data_reg;
    logic [arm_pkg::LEN_W-1:0] idx_reg;
    logic [arm_pkg::LEN_W-1:0] len_reg;
    logic [7:0]                peer_reg;
    logic [7:0]                seq_reg;
    logic [3:0]                attempt_reg;
    logic                      rd_final;

    assign pop = (state_reg == ST_IDLE) && !empty;
    assign rd_final = idx_reg == (len_reg - 1'b1);

    // replay bytes come straight from the read register
    assign result_valid = out_valid_reg || rd_valid_reg;
    always_comb
    begin
        if (rd_valid_reg)
        begin
            result.kind = arm_pkg::KIND_TX;
            result.tx_byte = rd_data_reg;
            result.last = rd_last_reg;
            result.peer_addr = peer_reg;
            result.seq_out = seq_reg;
            result.attempt = attempt_reg;
        end
        else
        begin
            result = out_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.op == arm_pkg::CMD_TX && head.wr_en)
        begin
            store_mem[head.count[AW-1:0]] <= head.data;
        end
        if (state_reg == ST_REPLAY)
        begin
            rd_data_reg <= store_mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.kind <= head.kind;
            out_reg.tx_byte <= head.data;
            out_reg.last <= head.last;
            out_reg.peer_addr <= head.peer;
            out_reg.seq_out <= head.seq;
            out_reg.attempt <= head.attempt;
            if (head.op == arm_pkg::CMD_REPLAY)
            begin
                len_reg <= head.count;
                peer_reg <= head.peer;
                seq_reg <= head.seq;
                attempt_reg <= head.attempt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    rd_valid_reg <= 1'b0;
                    out_valid_reg <= 1'b0;
                    if (!empty)
                    begin
                        if (head.op == arm_pkg::CMD_REPLAY)
                        begin
                            idx_reg <= '0;
                            state_reg <= ST_REPLAY;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_REPLAY:
                begin
                    out_valid_reg <= 1'b0;
                    rd_valid_reg <= 1'b1;
                    rd_last_reg <= rd_final;
                    idx_reg <= idx_reg + 1'b1;
                    if (rd_final)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/ack_retransmit_manager_core.sv
// Stop-and-wait retransmission manager with one pending packet slot. The front end takes one
// transaction (send byte, ack or millisecond tick) per cycle whenever busy is low and keeps the
// slot, retry and countdown state; busy rises only when its 4-entry command queue is full. The
// back end drains that queue: a send byte or a report (ack confirmed, gave up) is written to the
// queue and then to the back end's output register, waiting while a replay runs; a replay walks
// the packet store through its single read port, one byte per cycle, and the back end takes no
// new command until the last byte of the replay is read. There is no clearing pass after reset.
// Results cannot be stalled: each is shown for one cycle with result_valid high.
module ack_retransmit_manager_core #(
    parameter int PKT_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  arm_pkg::item_t                 item,
    input  logic                           cfg_we,
    input  logic [arm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           result_valid,
    output arm_pkg::result_t               result
);

    logic          accept;
    logic          push;
    arm_pkg::cmd_t push_cmd;
    arm_pkg::cmd_t head;
    logic          pop;
    logic          empty;
    logic          full;

    assign busy = full;
    assign accept = start && !full;

    arm_front #(
        .PKT_DEPTH (PKT_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .cmd       (push_cmd)
    );

    arm_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    arm_back #(
        .PKT_DEPTH (PKT_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
